/* hw/rtl/atrp_pkg.sv */
package atrp_pkg;

	localparam int SENSOR_COUNT_DEF = 4;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int AXIS_W = 18;
	localparam int SQ_W = 35;
	localparam int RAD_W = 59;
	localparam int ROOT_W = 30;
	localparam int CW = 52;
	localparam int ZW = 26;
	localparam int ANGLE_W = 15;
	localparam int ANGLE_LIMIT = 11520;
	localparam int ATAN_LEN = 24;

	typedef enum logic {
		CMD_COMPUTE = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] t;
		case (i)
			0: t = 26'sd2949120;
			1: t = 26'sd1740967;
			2: t = 26'sd919879;
			3: t = 26'sd466945;
			4: t = 26'sd234379;
			5: t = 26'sd117304;
			6: t = 26'sd58666;
			7: t = 26'sd29335;
			8: t = 26'sd14668;
			9: t = 26'sd7334;
			10: t = 26'sd3667;
			11: t = 26'sd1833;
			12: t = 26'sd917;
			13: t = 26'sd458;
			14: t = 26'sd229;
			15: t = 26'sd115;
			16: t = 26'sd57;
			17: t = 26'sd29;
			18: t = 26'sd14;
			19: t = 26'sd7;
			20: t = 26'sd4;
			21: t = 26'sd2;
			22: t = 26'sd1;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

/* hw/rtl/atrp_angle.sv */
module atrp_angle #(
	parameter int CORDIC_STEPS = atrp_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic en,
	input logic signed [atrp_pkg::AXIS_W-1:0] num,
	input logic signed [atrp_pkg::AXIS_W-1:0] p,
	input logic signed [atrp_pkg::AXIS_W-1:0] q,
	output logic signed [atrp_pkg::ANGLE_W-1:0] angle
);
	localparam int RW = atrp_pkg::ROOT_W;
	localparam int RADW = atrp_pkg::RAD_W;
	localparam int CW = atrp_pkg::CW;
	localparam int ZW = atrp_pkg::ZW;
	localparam int RS = RW;
	localparam int NS = CORDIC_STEPS;

	logic signed [2*atrp_pkg::AXIS_W-1:0] pp_s1, qq_s1;
	logic signed [atrp_pkg::AXIS_W-1:0] num_s1;
	logic [RADW-1:0] rad_s2 [RS+1];
	logic [RW:0] res_s2 [RS+1];
	logic signed [atrp_pkg::AXIS_W-1:0] num_s2 [RS+1];
	logic zero_s2 [RS+1];
	logic signed [CW-1:0] x_s3 [NS+1];
	logic signed [CW-1:0] y_s3 [NS+1];
	logic signed [ZW-1:0] z_s3 [NS+1];
	logic zero_s3 [NS+1];
	logic signed [ZW-1:0] zr;
	logic signed [ZW-10:0] zq;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1 <= p * p;
			qq_s1 <= q * q;
			num_s1 <= num;
		end
	end

	always_comb begin
		rad_s2[0] = RADW'({1'b0, pp_s1[2*atrp_pkg::AXIS_W-2:0]})
			+ RADW'({1'b0, qq_s1[2*atrp_pkg::AXIS_W-2:0]});
		rad_s2[0] = rad_s2[0] << 24;
		res_s2[0] = '0;
		num_s2[0] = num_s1;
		zero_s2[0] = (num_s1 == '0) && (pp_s1 == '0) && (qq_s1 == '0);
	end

	for (genvar k = 0; k < RS; k++) begin : g_root
		localparam int B = 2 * (RS - 1 - k);
		logic [RADW-1:0] trial;
		logic [RADW-1:0] rem_n;
		logic [RW:0] res_n;
		always_comb begin
			trial = (RADW'(res_s2[k]) << (RS - k)) + (RADW'(1) << B);
			if (rad_s2[k] >= trial) begin
				rem_n = rad_s2[k] - trial;
				res_n = res_s2[k] | ((RW+1)'(1) << (RS - 1 - k));
			end else begin
				rem_n = rad_s2[k];
				res_n = res_s2[k];
			end
		end
		if (k % 3 == 2) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s2[k+1] <= rem_n;
					res_s2[k+1] <= res_n;
					num_s2[k+1] <= num_s2[k];
					zero_s2[k+1] <= zero_s2[k];
				end
			end
		end else begin : g_pass
			assign rad_s2[k+1] = rem_n;
			assign res_s2[k+1] = res_n;
			assign num_s2[k+1] = num_s2[k];
			assign zero_s2[k+1] = zero_s2[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3[0] <= CW'(res_s2[RS]);
			y_s3[0] <= CW'(num_s2[RS]) <<< 12;
			z_s3[0] <= '0;
			zero_s3[0] <= zero_s2[RS];
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [CW-1:0] nx, ny;
		logic signed [ZW-1:0] nz;
		always_comb begin
			if (y_s3[i] > 0) begin
				nx = x_s3[i] + (y_s3[i] >>> i);
				ny = y_s3[i] - (x_s3[i] >>> i);
				nz = z_s3[i] + atrp_pkg::atan_q16(i);
			end else begin
				nx = x_s3[i] - (y_s3[i] >>> i);
				ny = y_s3[i] + (x_s3[i] >>> i);
				nz = z_s3[i] - atrp_pkg::atan_q16(i);
			end
		end
		if (i % 2 == 1) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) begin
					x_s3[i+1] <= nx;
					y_s3[i+1] <= ny;
					z_s3[i+1] <= nz;
					zero_s3[i+1] <= zero_s3[i];
				end
			end
		end else begin : g_pass
			assign x_s3[i+1] = nx;
			assign y_s3[i+1] = ny;
			assign z_s3[i+1] = nz;
			assign zero_s3[i+1] = zero_s3[i];
		end
	end

	always_comb begin
		zr = z_s3[NS] + ZW'(256);
		zq = zr[ZW-1:9];
		if (zero_s3[NS])
			angle = '0;
		else if (zq > (ZW-9)'(atrp_pkg::ANGLE_LIMIT))
			angle = atrp_pkg::ANGLE_W'(atrp_pkg::ANGLE_LIMIT);
		else if (zq < -(ZW-9)'(atrp_pkg::ANGLE_LIMIT))
			angle = -atrp_pkg::ANGLE_W'(atrp_pkg::ANGLE_LIMIT);
		else
			angle = zq[atrp_pkg::ANGLE_W-1:0];
	end

endmodule

/* hw/rtl/accel_tilt_roll_pitch.sv */
// channel | dir | tdata (low bit up)                                        | tuser
// s_axis  | in  | sensor_index[1:0] axis_select[3:2] offset_value[19:4]     | cmd
//         |     | accel_first[35:20] accel_second[51:36] accel_third[67:52]  |
// m_axis  | out | out_sensor[1:0] roll_angle[16:2] pitch_angle[31:17]        | -
// One item per cycle while m_axis is not stalled; the pipeline stages, in order, are
// offset add, squares, ten root stages, CORDIC load, two CORDIC steps per stage.
// Reset clears valid bits only; the offset table holds garbage until loaded.
// A stall on m_axis freezes the whole pipe; s_axis_tready follows it.
module accel_tilt_roll_pitch #(
	parameter int SENSOR_COUNT = atrp_pkg::SENSOR_COUNT_DEF,
	parameter int CORDIC_STEPS = atrp_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [71:0] s_axis_tdata, // sensor_index, axis_select, offset_value, accel x3
	input logic s_axis_tuser, // cmd
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata // out_sensor, roll_angle, pitch_angle
);
	localparam int AW = atrp_pkg::AXIS_W;
	localparam int LAT = 1 + 10 + 1 + (CORDIC_STEPS / 2) + 1;
	localparam int DEPTH = SENSOR_COUNT * 3;
	localparam int IW = $clog2(DEPTH);

	logic en;
	logic [1:0] sidx;
	logic [1:0] asel;
	logic signed [AW-1:0] tab [DEPTH];
	logic signed [AW-1:0] a0_s1, a1_s1, a2_s1, na2_s1;
	logic signed [atrp_pkg::ANGLE_W-1:0] roll, pitch;
	logic vld_q [LAT];
	logic [1:0] sen_q [LAT];
	logic take;

	assign en = m_axis_tready || !m_axis_tvalid;
	assign s_axis_tready = en;
	assign sidx = s_axis_tdata[1:0];
	assign asel = s_axis_tdata[3:2];
	assign take = s_axis_tvalid && en && (32'(sidx) < SENSOR_COUNT);

	always_ff @(posedge clk) begin
		if (take && s_axis_tuser == atrp_pkg::CMD_LOAD && asel != 2'd3)
			tab[IW'(32'(sidx) * 3 + 32'(asel))] <= AW'($signed(s_axis_tdata[19:4]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a0_s1 <= AW'($signed(s_axis_tdata[35:20])) + tab[IW'(32'(sidx) * 3)];
			a1_s1 <= AW'($signed(s_axis_tdata[51:36])) + tab[IW'(32'(sidx) * 3 + 1)];
			a2_s1 <= AW'($signed(s_axis_tdata[67:52])) + tab[IW'(32'(sidx) * 3 + 2)];
			na2_s1 <= -(AW'($signed(s_axis_tdata[67:52])) + tab[IW'(32'(sidx) * 3 + 2)]);
		end
	end

	atrp_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en), .num(a0_s1), .p(a1_s1), .q(a2_s1), .angle(roll)
	);
	atrp_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en), .num(na2_s1), .p(a0_s1), .q(a1_s1), .angle(pitch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= take && s_axis_tuser == atrp_pkg::CMD_COMPUTE;
			for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sen_q[0] <= sidx;
			for (int k = 1; k < LAT; k++) sen_q[k] <= sen_q[k-1];
		end
	end

	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata = {pitch, roll, sen_q[LAT-1]};

	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (m_axis_tready || !m_axis_tvalid));
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
	a_valid_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(m_axis_tvalid));
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[16:2]) <= atrp_pkg::ANGLE_LIMIT
			&& $signed(m_axis_tdata[16:2]) >= -atrp_pkg::ANGLE_LIMIT);

endmodule

/* tb/accel_tilt_roll_pitch_tb.sv */
`timescale 1ns / 100ps

class tilt_scoreboard;
	typedef struct {
		logic [1:0] sensor;
		logic signed [14:0] roll;
		logic signed [14:0] pitch;
	} angles_t;

	longint offsets[12];
	angles_t pending[$];
	int errors;

	static function longint asr(longint v, int k);
		return v >>> k;
	endfunction

	static function longint isqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	static function logic signed [14:0] tilt(longint num, longint p, longint q);
		longint unsigned s;
		longint x, y, z, nx, ny, o;
		s = p * p + q * q;
		if (num == 0 && s == 0)
			return 0;
		x = isqrt(s << 24);
		y = num * 4096;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + asr(y, i);
				ny = y - asr(x, i);
				z += atrp_pkg::atan_q16(i);
			end else begin
				nx = x - asr(y, i);
				ny = y + asr(x, i);
				z -= atrp_pkg::atan_q16(i);
			end
			x = nx;
			y = ny;
		end
		o = asr(z + 256, 9);
		if (o > 11520)
			o = 11520;
		if (o < -11520)
			o = -11520;
		return o[14:0];
	endfunction

	function void note_item(logic cmd, logic [71:0] d);
		logic [1:0] sen, ax;
		longint a0, a1, a2;
		angles_t e;
		sen = d[1:0];
		ax = d[3:2];
		if (cmd == atrp_pkg::CMD_LOAD) begin
			if (ax < 3)
				offsets[sen * 3 + ax] = longint'($signed(d[19:4]));
			return;
		end
		a0 = longint'($signed(d[35:20])) + offsets[sen * 3];
		a1 = longint'($signed(d[51:36])) + offsets[sen * 3 + 1];
		a2 = longint'($signed(d[67:52])) + offsets[sen * 3 + 2];
		e.sensor = sen;
		e.roll = tilt(a0, a1, a2);
		e.pitch = tilt(-a2, a0, a1);
		pending.push_back(e);
	endfunction

	function void check_result(logic [31:0] d);
		angles_t e;
		if (pending.size() == 0) begin
			$error("unexpected result %h", d);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (d[1:0] !== e.sensor) begin
			$error("out_sensor expected %0d actual %0d", e.sensor, d[1:0]);
			errors++;
		end
		if (d[16:2] !== e.roll) begin
			$error("roll_angle expected %0d actual %0d", e.roll, $signed(d[16:2]));
			errors++;
		end
		if (d[31:17] !== e.pitch) begin
			$error("pitch_angle expected %0d actual %0d", e.pitch, $signed(d[31:17]));
			errors++;
		end
	endfunction
endclass

module accel_tilt_roll_pitch_tb;
	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [31:0] m_axis_tdata;

	tilt_scoreboard sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 0;
	longint cycles = 0;

	always #5 clk = ~clk;

	accel_tilt_roll_pitch i_dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
	end

	task automatic send_item(logic cmd, logic [1:0] sen, logic [1:0] ax, logic [15:0] off,
			logic [15:0] f, logic [15:0] s, logic [15:0] t);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0, t, s, f, off, ax, sen};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(cmd, {4'b0, t, s, f, off, ax, sen});
	endtask

	task automatic load_offset(int sen, int ax, int val);
		send_item(atrp_pkg::CMD_LOAD, sen[1:0], ax[1:0], val[15:0],
			16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic sample(int sen, int f, int s, int t);
		send_item(atrp_pkg::CMD_COMPUTE, sen[1:0], 2'($urandom), 16'($urandom),
			f[15:0], s[15:0], t[15:0]);
	endtask

	function automatic int rnd_axis();
		case ($urandom_range(3))
			0: return $urandom_range(65535) - 32768;
			1: return $urandom_range(32) - 16;
			2: return ($urandom_range(1) ? 32767 : -32768);
			default: return $urandom_range(33000) - 16500;
		endcase
	endfunction

	task automatic wait_drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 12; i++)
			load_offset(i / 3, i % 3, 0);
		sample(0, 0, 0, 0);
		sample(1, 32767, 32767, 32767);
		sample(2, -32768, -32768, -32768);
		sample(3, 16384, 0, 0);
		sample(0, 0, 0, -16384);
		sample(1, 0, 16384, 0);
		load_offset(2, 3, 12345);
		load_offset(2, 0, 32767);
		load_offset(3, 2, -32768);
		sample(2, 32767, -1, 1);
		sample(3, -32768, 0, -32768);
		wait_drain();
		for (int ph = 0; ph < 5; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 62 : 29) : 0;
			recv_stall = (ph == 2) ? 62 : (ph == 3 ? 29 : 0);
			for (int n = 0; n < 260; n++) begin
				if (ph == 4 && n == 20)
					fork
						begin
							hold_off = 1;
							repeat (300) @(posedge clk);
							hold_off = 0;
						end
					join_none
				if ($urandom_range(9) == 0)
					load_offset($urandom_range(3), $urandom_range(3), $urandom_range(65535));
				else
					sample($urandom_range(3), rnd_axis(), rnd_axis(), rnd_axis());
			end
			wait_drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

/* files.f */
hw/rtl/atrp_pkg.sv
hw/rtl/atrp_angle.sv
hw/rtl/accel_tilt_roll_pitch.sv
tb/accel_tilt_roll_pitch_tb.sv
